@@ sv/multi_click_long_press_detector_top_defines.svh @@
// assertion macros used by the detector datapath
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef MULTI_CLICK_LONG_PRESS_DETECTOR_TOP_DEFINES_SVH
`define MULTI_CLICK_LONG_PRESS_DETECTOR_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define MCLPD_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
	else $error("detector check failed");

// condition implies consequence in the next cycle
`define MCLPD_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
	else $error("detector check failed");

`endif

@@ sv/mclpd_pkg.sv @@
// shared types, codes and field layout of the multi-click / long-press detector
// no dependencies
package mclpd_pkg;

	// fixed field widths
	localparam int DELAY_W   = 16;
	localparam int COUNT_W   = 3;
	localparam int ENTRY_W   = 30;
	localparam int CLICK_W   = 8;
	localparam int HOLD_W    = 16;
	localparam int NCLK_W    = 4;
	localparam int TARGET_W  = 8;
	localparam int ONOFF_W   = 2;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int INDEX_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int TDATA_W   = 24;
	localparam int IN_DATA_W = 8;

	// register storage and parameter defaults
	localparam int ENTRY_REGS       = 4;
	localparam int NUM_LINKS_DEF    = 4;
	localparam int TIMER_BITS_DEF   = 16;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd500;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY0 = 3'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PULSE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ACTION = 2'd2;

	// switch status codes
	localparam logic [STATUS_W-1:0] SW_RELEASED = 2'd0;
	localparam logic [STATUS_W-1:0] SW_PRESSED  = 2'd1;
	localparam logic [STATUS_W-1:0] SW_LONG     = 2'd2;

	// commands from the controller
	typedef struct packed {
		logic take;
		logic eval;
		logic scan;
		logic emit_status;
	} mclpd_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic out_free;
		logic scan_due;
		logic scan_stop;
	} mclpd_stat_t;

	// entry field extraction
	function automatic logic [NCLK_W-1:0] entry_clicks(input logic [ENTRY_W-1:0] e);
		return e[3:0];
	endfunction

	function automatic logic [HOLD_W-1:0] entry_hold(input logic [ENTRY_W-1:0] e);
		return e[19:4];
	endfunction

	function automatic logic [ONOFF_W-1:0] entry_onoff(input logic [ENTRY_W-1:0] e);
		return e[21:20];
	endfunction

	function automatic logic [TARGET_W-1:0] entry_target(input logic [ENTRY_W-1:0] e);
		return e[29:22];
	endfunction

endpackage

@@ sv/mclpd_ctrl.sv @@
// tick sequencer of the detector: accept, evaluate, entry walk, status
// depends on mclpd_pkg
module mclpd_ctrl import mclpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  mclpd_stat_t stat,
	output mclpd_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_STAT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;

	// command decode
	always_comb begin
		cmd             = '0;
		s_tready        = (state_q == ST_IDLE);
		cmd.take        = (state_q == ST_IDLE) && s_tvalid;
		cmd.eval        = (state_q == ST_EVAL) && stat.out_free;
		cmd.scan        = (state_q == ST_SCAN) && stat.out_free;
		cmd.emit_status = (state_q == ST_STAT) && stat.out_free;
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take) state_next = ST_EVAL;
			end
			ST_EVAL: begin
				if (cmd.eval) state_next = stat.scan_due ? ST_SCAN : ST_STAT;
			end
			ST_SCAN: begin
				if (cmd.scan && stat.scan_stop) state_next = ST_STAT;
			end
			ST_STAT: begin
				if (cmd.emit_status) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ sv/mclpd_datapath.sv @@
// datapath of the detector: config registers, timers, click count, entry walk,
// output register; depends on mclpd_pkg and the assertion macro header
`include "multi_click_long_press_detector_top_defines.svh"
module mclpd_datapath import mclpd_pkg::*; #(
	parameter int NUM_LINKS  = NUM_LINKS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_level,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,
	output logic [KIND_W-1:0]    m_tuser,
	output logic                 m_tlast,
	input  mclpd_cmd_t           cmd,
	output mclpd_stat_t          stat
);

	localparam int LINK_REGS = (NUM_LINKS < ENTRY_REGS) ? NUM_LINKS : ENTRY_REGS;
	localparam int CMP_W     = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

	// configuration
	logic [DELAY_W-1:0] delay_q;
	logic [COUNT_W-1:0] count_q;
	logic [ENTRY_W-1:0] entry_q [LINK_REGS];

	// tick state
	logic                  level_q;
	logic                  prev_q;
	logic [TIMER_BITS-1:0] press_q;
	logic [TIMER_BITS-1:0] release_q;
	logic [CLICK_W-1:0]    click_q;
	logic                  flag_q;
	logic                  hold_mode_q;
	logic [COUNT_W-1:0]    idx_q;

	// output register
	logic                 out_valid_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [INDEX_W-1:0]   out_index_q;
	logic [TARGET_W-1:0]  out_target_q;
	logic [ONOFF_W-1:0]   out_onoff_q;
	logic [CLICK_W-1:0]   out_click_q;
	logic                 out_last_q;

	logic                 edge_seen;
	logic                 pulse_case;
	logic                 group_due;
	logic                 hold_due;
	logic [CMP_W-1:0]     press_ext;
	logic [CMP_W-1:0]     release_ext;
	logic [CMP_W-1:0]     delay_ext;
	logic [CMP_W-1:0]     hold_ext;
	logic [ENTRY_W-1:0]   sel_entry;
	logic [COUNT_W-1:0]   n_used;
	logic                 scan_end;
	logic                 hit;
	logic [CLICK_W-1:0]   click_inc;
	logic [STATUS_W-1:0]  status_now;
	logic                 emit;
	logic [KIND_W-1:0]    emit_kind;
	logic [STATUS_W-1:0]  emit_status;
	logic [CLICK_W-1:0]   emit_click;

	assign cfg_ready = 1'b1;

	// tick evaluation
	always_comb begin
		press_ext   = CMP_W'(press_q);
		release_ext = CMP_W'(release_q);
		delay_ext   = CMP_W'(delay_q);
		edge_seen   = (level_q != prev_q);
		pulse_case  = edge_seen && level_q && !flag_q;
		group_due   = !edge_seen && level_q && (release_ext > delay_ext);
		hold_due    = !edge_seen && !level_q && (press_ext > delay_ext);
		click_inc   = (click_q == '1) ? click_q : click_q + 1'b1;
		status_now  = level_q ? SW_RELEASED : (flag_q ? SW_LONG : SW_PRESSED);
	end

	// entry walk: one entry per cycle while the output register is free
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < LINK_REGS; i++) begin
			if (idx_q == COUNT_W'(i)) sel_entry = entry_q[i];
		end
		n_used   = (count_q > COUNT_W'(LINK_REGS)) ? COUNT_W'(LINK_REGS) : count_q;
		scan_end = (idx_q >= n_used);
		hold_ext = CMP_W'(entry_hold(sel_entry));
		if (hold_mode_q) begin
			hit = (entry_hold(sel_entry) != '0) && (press_ext > hold_ext);
		end else begin
			hit = (entry_clicks(sel_entry) != '0)
				&& (CLICK_W'(entry_clicks(sel_entry)) == click_q);
		end
	end

	assign stat.out_free  = !out_valid_q || m_tready;
	assign stat.scan_due  = group_due || hold_due;
	assign stat.scan_stop = scan_end || (hit && hold_mode_q);

	// result selection
	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_STATUS;
		emit_status = status_now;
		emit_click  = click_q;
		priority if (cmd.eval && pulse_case) begin
			emit        = 1'b1;
			emit_kind   = KIND_PULSE;
			emit_status = SW_RELEASED;
			emit_click  = click_inc;
		end else if (cmd.scan && !scan_end && hit) begin
			emit      = 1'b1;
			emit_kind = KIND_ACTION;
		end else if (cmd.emit_status) begin
			emit = 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			count_q <= '0;
			for (int i = 0; i < LINK_REGS; i++) entry_q[i] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_DELAY) delay_q <= cfg_data[DELAY_W-1:0];
			if (cfg_index == CFG_LINKS) count_q <= cfg_data[COUNT_W-1:0];
			for (int i = 0; i < LINK_REGS; i++) begin
				if (cfg_index == CFG_ENTRY0 + CFG_IDX_W'(i)) entry_q[i] <= cfg_data;
			end
		end
	end

	// timers, click count and long-press flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 1'b1;
			prev_q      <= 1'b1;
			press_q     <= '0;
			release_q   <= '0;
			click_q     <= '0;
			flag_q      <= 1'b0;
			hold_mode_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (cmd.take) begin
				level_q   <= s_level;
				press_q   <= (press_q == '1) ? press_q : press_q + 1'b1;
				release_q <= (release_q == '1) ? release_q : release_q + 1'b1;
			end
			if (cmd.eval) begin
				prev_q      <= level_q;
				idx_q       <= '0;
				hold_mode_q <= !level_q;
				if (edge_seen && !level_q) begin
					press_q <= '0;
					click_q <= '0;
				end else if (edge_seen && flag_q) begin
					flag_q <= 1'b0;
				end else if (pulse_case) begin
					click_q   <= click_inc;
					release_q <= '0;
				end else if (hold_due) begin
					flag_q <= 1'b1;
				end
			end
			if (cmd.scan) begin
				idx_q <= idx_q + 1'b1;
				if (scan_end) begin
					if (!hold_mode_q) click_q <= '0;
				end else if (hit && hold_mode_q) begin
					press_q <= '0;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= emit_kind;
			out_status_q <= emit_status;
			out_click_q  <= emit_click;
			out_last_q   <= (emit_kind == KIND_STATUS);
			if (emit_kind == KIND_ACTION) begin
				out_index_q  <= idx_q[INDEX_W-1:0];
				out_target_q <= entry_target(sel_entry);
				out_onoff_q  <= entry_onoff(sel_entry);
			end else begin
				out_index_q  <= '0;
				out_target_q <= '0;
				out_onoff_q  <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_click_q, out_onoff_q, out_target_q, out_index_q,
		out_status_q};

	// a new result never overwrites one still waiting
	`MCLPD_ASSERT_SAME(a_no_overwrite, out_valid_q && !m_tready, !emit)
	// the status result closes the tick
	`MCLPD_ASSERT_NEXT(a_status_last, cmd.emit_status,
		m_tvalid && m_tlast && (m_tuser == KIND_STATUS))
	// the entry walk index never exceeds the number of entry registers
	`MCLPD_ASSERT_SAME(a_idx_range, cmd.scan, idx_q <= COUNT_W'(LINK_REGS))

endmodule

@@ sv/multi_click_long_press_detector_top.sv @@
// Multi-click and long-press detector for one push switch. Each input transfer
// carries one sampled switch level (0 pressed), and yields zero or one short-
// release pulse, then any fired linked actions, then a status result marked by
// tlast. A tick steps through accept, evaluate and status; a due entry walk
// runs between evaluate and status, one link entry per step plus a closing
// step, the entry walk sharing one comparator. A long-press walk stops at the
// first entry that fires. Output stalls hold evaluate, walk and status steps.
// Only one tick is in work at a time. Configuration writes are always accepted.
// depends on mclpd_pkg, mclpd_ctrl and mclpd_datapath
module multi_click_long_press_detector_top import mclpd_pkg::*; #(
	parameter int NUM_LINKS  = NUM_LINKS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input tick stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,  // [0] switch_level, [7:1] zero
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] switch_status, [3:2] entry_index, [11:4] target_id,
	// [13:12] on_off_request, [21:14] click_total, [23:22] zero
	output logic [TDATA_W-1:0]   m_tdata,
	output logic [KIND_W-1:0]    m_tuser,  // [1:0] result_kind
	output logic                 m_tlast,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data
);

	mclpd_cmd_t  cmd;
	mclpd_stat_t stat;

	// tick sequencer
	mclpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// timers, entries and output register
	mclpd_datapath #(
		.NUM_LINKS  (NUM_LINKS),
		.TIMER_BITS (TIMER_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_level   (s_tdata[0]),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
